[hdl/ptu_pkg.sv]
package ptu_pkg;

  typedef enum logic [2:0] {
    REQ_READ      = 3'd0,
    REQ_WRITE     = 3'd1,
    REQ_MAP       = 3'd2,
    REQ_CLEAR     = 3'd3,
    REQ_CLEAR_ALL = 3'd4,
    REQ_SET_TIME  = 3'd5,
    REQ_QUERY     = 3'd6
  } req_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INV   = 2'd1;
  localparam logic [1:0] ST_FAULT = 2'd2;

  localparam int VADDR_W = 16;
  localparam int FRAME_W = 6;
  localparam int TIME_W  = 16;
  localparam int PHYS_W  = 14;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
  } ptu_cmd_t;

endpackage

[hdl/page_table_translation_unit.sv]
// Single-level page table translation unit.
// Input channel (in_valid / in_stall) carries one request item: read or write
// access by virtual address, map, clear page, clear all, set time or query.
// Result channel (out_valid / out_stall) returns exactly one item per request:
// status, translated address, memory write enable and data, entry fields on a
// query, and the sticky fault flag with the last faulting address.
// An item's page number is registered in the accept cycle; in the next cycle
// the offset is registered and the entry read issued to a registered-read
// RAM; in S_LOOK, once the output register is free, the entry is updated and
// the result registered. A new item is taken only in idle or as the last one
// commits: the read-then-update pass uses the single table RAM port pair.
// A finished result waits in the output register while the next item is
// taken; if the receiver stalls, the next update is held until it drains.
// Reset empties the table at once through per-page live flags, clears the
// fault flag and address, and drops out_valid. No setup pass is needed.
module page_table_translation_unit
  import ptu_pkg::*;
#(
  parameter int PAGE_COUNT  = 64,
  parameter int PAGE_SIZE   = 256,
  parameter int FRAME_COUNT = 64,
  parameter int TIME_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_req_type,
  input  logic [15:0]         in_virt_addr,
  input  logic [5:0]          in_page_index,
  input  logic [5:0]          in_frame_number,
  input  logic [15:0]         in_time_now,
  input  logic signed [31:0]  in_write_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [13:0]         out_phys_addr,
  output logic                out_mem_write_en,
  output logic signed [31:0]  out_mem_write_data,
  output logic                out_entry_valid,
  output logic [5:0]          out_entry_frame,
  output logic                out_entry_accessed,
  output logic                out_entry_dirty,
  output logic [15:0]         out_entry_last_used,
  output logic                out_fault_seen,
  output logic [15:0]         out_fault_address
);

  ptu_cmd_t cmd;

  ptu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd)
  );

  ptu_dp #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_SIZE  (PAGE_SIZE),
    .FRAME_COUNT(FRAME_COUNT),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_req_type        (in_req_type),
    .in_virt_addr       (in_virt_addr),
    .in_page_index      (in_page_index),
    .in_frame_number    (in_frame_number),
    .in_time_now        (in_time_now),
    .in_write_data      (in_write_data),
    .out_status         (out_status),
    .out_phys_addr      (out_phys_addr),
    .out_mem_write_en   (out_mem_write_en),
    .out_mem_write_data (out_mem_write_data),
    .out_entry_valid    (out_entry_valid),
    .out_entry_frame    (out_entry_frame),
    .out_entry_accessed (out_entry_accessed),
    .out_entry_dirty    (out_entry_dirty),
    .out_entry_last_used(out_entry_last_used),
    .out_fault_seen     (out_fault_seen),
    .out_fault_address  (out_fault_address)
  );

endmodule

[hdl/ptu_ram.sv]
module ptu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/ptu_ctrl.sv]
module ptu_ctrl
  import ptu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output ptu_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ADDR = 3'b010,
    S_LOOK = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   take_ok;

  assign out_free = !out_valid_r || !out_stall;
  assign take_ok  = (state_r == S_IDLE) || ((state_r == S_LOOK) && out_free);

  assign in_stall    = !take_ok;
  assign cmd.capture = in_valid && take_ok;
  assign cmd.lookup  = (state_r == S_ADDR);
  assign cmd.commit  = (state_r == S_LOOK) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        if (out_free) begin
          state_nxt = in_valid ? S_ADDR : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/ptu_dp.sv]
module ptu_dp
  import ptu_pkg::*;
#(
  parameter int PAGE_COUNT  = 64,
  parameter int PAGE_SIZE   = 256,
  parameter int FRAME_COUNT = 64,
  parameter int TIME_BITS   = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ptu_cmd_t                  cmd,
  input  logic [2:0]                in_req_type,
  input  logic [VADDR_W-1:0]        in_virt_addr,
  input  logic [5:0]                in_page_index,
  input  logic [FRAME_W-1:0]        in_frame_number,
  input  logic [TIME_W-1:0]         in_time_now,
  input  logic signed [31:0]        in_write_data,
  output logic [1:0]                out_status,
  output logic [PHYS_W-1:0]         out_phys_addr,
  output logic                      out_mem_write_en,
  output logic signed [31:0]        out_mem_write_data,
  output logic                      out_entry_valid,
  output logic [FRAME_W-1:0]        out_entry_frame,
  output logic                      out_entry_accessed,
  output logic                      out_entry_dirty,
  output logic [TIME_W-1:0]         out_entry_last_used,
  output logic                      out_fault_seen,
  output logic [VADDR_W-1:0]        out_fault_address
);

  localparam int PI_W      = $clog2(PAGE_COUNT);
  localparam int DIV_L     = $clog2(PAGE_SIZE);
  localparam int DIV_SHIFT = VADDR_W + DIV_L;
  localparam logic [63:0] DIV_M64 =
    ((64'd1 << DIV_SHIFT) + 64'(PAGE_SIZE) - 64'd1) / 64'(PAGE_SIZE);
  localparam logic [16:0] DIV_M = DIV_M64[16:0];

  localparam int E_D     = TIME_BITS;
  localparam int E_A     = TIME_BITS + 1;
  localparam int E_F_LSB = TIME_BITS + 2;
  localparam int E_V     = TIME_BITS + 2 + FRAME_W;
  localparam int ENT_W   = TIME_BITS + 3 + FRAME_W;

  req_t                req_r;
  logic [VADDR_W-1:0]  vaddr_r;
  logic [5:0]          pidx_r;
  logic [FRAME_W-1:0]  frame_r;
  logic [TIME_W-1:0]   time_r;
  logic signed [31:0]  wdata_r;
  logic [VADDR_W-1:0]  page_r;

  logic [VADDR_W-1:0]  off_r;
  logic [PI_W-1:0]     idx_r;
  logic                inrange_r;
  logic                live_hit_r;
  logic [PAGE_COUNT-1:0] live_r, live_nxt;

  logic                fault_r, fault_nxt;
  logic [VADDR_W-1:0]  fault_addr_r, fault_addr_nxt;

  logic [32:0]         div_prod;
  logic [32:0]         div_quo;
  logic [31:0]         page_base;
  logic [VADDR_W-1:0]  addr_sel;
  logic [PI_W-1:0]     idx_sel;
  logic                inrange_sel;

  logic [ENT_W-1:0]    ram_rdata;
  logic [ENT_W-1:0]    ent;
  logic [ENT_W-1:0]    ent_nxt;
  logic                ent_we;
  logic [23:0]         phys_full;
  logic [31:0]         time_wide;
  logic [TIME_BITS-1:0] time_store;
  logic [31:0]         last_wide;

  logic [1:0]          status_nxt;
  logic [PHYS_W-1:0]   phys_nxt;
  logic                mwe_nxt;
  logic signed [31:0]  mwd_nxt;
  logic                ev_nxt;
  logic [FRAME_W-1:0]  ef_nxt;
  logic                ea_nxt;
  logic                ed_nxt;
  logic [TIME_W-1:0]   et_nxt;

  assign div_prod = 33'(in_virt_addr) * 33'(DIV_M);
  assign div_quo  = div_prod >> DIV_SHIFT;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= req_t'(in_req_type);
      vaddr_r <= in_virt_addr;
      pidx_r  <= in_page_index;
      frame_r <= in_frame_number;
      time_r  <= in_time_now;
      wdata_r <= in_write_data;
      page_r  <= div_quo[VADDR_W-1:0];
    end
  end

  assign page_base   = 32'(page_r) * 32'(PAGE_SIZE);
  assign addr_sel    = ((req_r == REQ_READ) || (req_r == REQ_WRITE)) ?
                       page_r : VADDR_W'(pidx_r);
  assign idx_sel     = addr_sel[PI_W-1:0];
  assign inrange_sel = 32'(addr_sel) < 32'(PAGE_COUNT);

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      off_r      <= vaddr_r - page_base[VADDR_W-1:0];
      idx_r      <= idx_sel;
      inrange_r  <= inrange_sel;
      live_hit_r <= inrange_sel ? live_r[idx_sel] : 1'b0;
    end
  end

  ptu_ram #(
    .WIDTH(ENT_W),
    .DEPTH(PAGE_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (cmd.commit && ent_we),
    .waddr(idx_r),
    .wdata(ent_nxt),
    .re   (cmd.lookup),
    .raddr(idx_sel),
    .rdata(ram_rdata)
  );

  assign ent        = live_hit_r ? ram_rdata : '0;
  assign phys_full  = 24'(ent[E_F_LSB +: FRAME_W]) * 24'(PAGE_SIZE) + 24'(off_r);
  assign time_wide  = 32'(time_r);
  assign time_store = time_wide[TIME_BITS-1:0];
  assign last_wide  = 32'(ent[TIME_BITS-1:0]);

  always_comb begin
    status_nxt     = ST_OK;
    phys_nxt       = '0;
    mwe_nxt        = 1'b0;
    mwd_nxt        = '0;
    ev_nxt         = 1'b0;
    ef_nxt         = '0;
    ea_nxt         = 1'b0;
    ed_nxt         = 1'b0;
    et_nxt         = '0;
    ent_nxt        = ent;
    ent_we         = 1'b0;
    live_nxt       = live_r;
    fault_nxt      = fault_r;
    fault_addr_nxt = fault_addr_r;
    case (req_r)
      REQ_READ, REQ_WRITE: begin
        if (!inrange_r) begin
          status_nxt = ST_INV;
        end else if (!ent[E_V]) begin
          status_nxt     = ST_FAULT;
          fault_nxt      = 1'b1;
          fault_addr_nxt = vaddr_r;
        end else begin
          phys_nxt = phys_full[PHYS_W-1:0];
          if (req_r == REQ_WRITE) begin
            ent_nxt[E_D] = 1'b1;
            mwe_nxt      = 1'b1;
            mwd_nxt      = wdata_r;
          end else begin
            ent_nxt[E_A] = 1'b1;
          end
          ent_nxt[TIME_BITS-1:0] = time_store;
          ent_we = 1'b1;
        end
      end
      REQ_MAP: begin
        if (!inrange_r || (32'(frame_r) >= 32'(FRAME_COUNT))) begin
          status_nxt = ST_INV;
        end else begin
          ent_nxt[E_V]               = 1'b1;
          ent_nxt[E_F_LSB +: FRAME_W] = frame_r;
          ent_we                     = 1'b1;
        end
      end
      REQ_CLEAR: begin
        if (!inrange_r) begin
          status_nxt = ST_INV;
        end else begin
          live_nxt[idx_r] = 1'b0;
        end
      end
      REQ_CLEAR_ALL: begin
        live_nxt = '0;
      end
      REQ_SET_TIME: begin
        if (!inrange_r) begin
          status_nxt = ST_INV;
        end else begin
          ent_nxt[TIME_BITS-1:0] = time_store;
          ent_we = 1'b1;
        end
      end
      REQ_QUERY: begin
        if (!inrange_r) begin
          status_nxt = ST_INV;
        end else begin
          ev_nxt = ent[E_V];
          ef_nxt = ent[E_F_LSB +: FRAME_W];
          ea_nxt = ent[E_A];
          ed_nxt = ent[E_D];
          et_nxt = last_wide[TIME_W-1:0];
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
    if (ent_we) begin
      live_nxt[idx_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r       <= '0;
      fault_r      <= 1'b0;
      fault_addr_r <= '0;
    end else if (cmd.commit) begin
      live_r       <= live_nxt;
      fault_r      <= fault_nxt;
      fault_addr_r <= fault_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status          <= status_nxt;
      out_phys_addr       <= phys_nxt;
      out_mem_write_en    <= mwe_nxt;
      out_mem_write_data  <= mwd_nxt;
      out_entry_valid     <= ev_nxt;
      out_entry_frame     <= ef_nxt;
      out_entry_accessed  <= ea_nxt;
      out_entry_dirty     <= ed_nxt;
      out_entry_last_used <= et_nxt;
      out_fault_seen      <= fault_nxt;
      out_fault_address   <= fault_addr_nxt;
    end
  end

endmodule

[hdl/ptu_checker.sv]
module ptu_checker
  import ptu_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [1:0]          out_status,
  input logic [13:0]         out_phys_addr,
  input logic                out_mem_write_en,
  input logic                out_fault_seen
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mem_write_en |-> out_status == ST_OK)
    else $error("memory write issued on a failed access");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_phys_addr == '0 && !out_mem_write_en)
    else $error("failed request carries an address or a write");

  a_fault_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FAULT |-> out_fault_seen)
    else $error("page fault not latched");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken while the previous one is still in the table pass");

endmodule

bind page_table_translation_unit ptu_checker u_ptu_checker (.*);
